### hdl/bbc_pkg.sv
// Shared constants and control types for the LRU buffer cache.
// Used by bbc_ctrl, bbc_dp and the top level block_buffer_cache_lru.
// No dependencies.
`default_nettype none

package bbc_pkg;

    localparam int SLOTS  = 32;
    localparam int SLOT_W = $clog2(SLOTS);
    // levels of the pairwise oldest-slot reduction
    localparam int LVLS   = $clog2(SLOTS);
    localparam int CAND_N = 1 << LVLS;
    localparam int LVL_W  = (LVLS > 1) ? $clog2(LVLS) : 1;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PIN     = 2'd2;
    localparam logic [1:0] OP_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_COUNT  = 2'd2;

    localparam logic [7:0] RC_MAX = 8'hFF;

    typedef struct packed {
        logic load;    // capture request, tag match and candidate row
        logic reduce;  // one level of the oldest-slot reduction
        logic commit;  // apply state update and fill the output register
    } dp_cmd_t;

    typedef struct packed {
        logic in_miss; // request on the input ports is a read that misses
    } dp_stat_t;

endpackage

`default_nettype wire

### hdl/bbc_dp.sv
// Datapath of the LRU buffer cache: tag store, counts, timestamps,
// tag match, shared oldest-slot reducer and result register.
// Depends on bbc_pkg.
`default_nettype none

module bbc_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bbc_pkg::dp_cmd_t cmd,
    output bbc_pkg::dp_stat_t     stat,
    input  wire logic [1:0]       op,
    input  wire logic [7:0]       dev,
    input  wire logic [31:0]      block,
    input  wire logic [4:0]       slot_in,
    output logic [4:0]            slot,
    output logic                  hit,
    output logic                  need_fill,
    output logic [1:0]            status
);

    logic [7:0]  tag_dev_reg    [bbc_pkg::SLOTS];
    logic [31:0] tag_block_reg  [bbc_pkg::SLOTS];
    logic        slot_valid_reg [bbc_pkg::SLOTS];
    logic [7:0]  ref_count_reg  [bbc_pkg::SLOTS];
    logic [31:0] last_use_reg   [bbc_pkg::SLOTS];
    logic [31:0] use_clock_reg;

    // request capture
    logic [1:0]  op_reg;
    logic [7:0]  dev_reg;
    logic [31:0] block_reg;
    logic [4:0]  slot_in_reg;
    logic        hit_reg;
    logic [bbc_pkg::SLOT_W-1:0] hit_idx_reg;

    // candidate row of the oldest-slot reduction
    logic [31:0]                cand_stamp_reg [bbc_pkg::CAND_N];
    logic [bbc_pkg::SLOT_W-1:0] cand_idx_reg   [bbc_pkg::CAND_N];
    logic                       cand_ok_reg    [bbc_pkg::CAND_N];

    // result register
    logic [4:0] slot_reg;
    logic       hit_out_reg;
    logic       fill_reg;
    logic [1:0] status_reg;

    logic                       any_match;
    logic [bbc_pkg::SLOT_W-1:0] match_idx;

    // lowest slot whose tag equals the request on the ports
    always_comb
    begin
        any_match = 1'b0;
        match_idx = '0;
        for (int i = bbc_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (tag_dev_reg[i] == dev && tag_block_reg[i] == block)
            begin
                any_match = 1'b1;
                match_idx = bbc_pkg::SLOT_W'(i);
            end
        end
    end

    assign stat.in_miss = (op == bbc_pkg::OP_READ) && !any_match;

    logic [bbc_pkg::SLOT_W-1:0] tgt_idx;
    logic [7:0] rc_cur;
    logic [7:0] rc_new;
    logic       slot_ok;
    logic       wr_rc;
    logic       wr_tag;
    logic       wr_stamp;
    logic [4:0] res_slot;
    logic       res_hit;
    logic       res_fill;
    logic [1:0] res_status;

    always_comb
    begin
        slot_ok = ({27'd0, slot_in_reg} < 32'(bbc_pkg::SLOTS));
        if (op_reg == bbc_pkg::OP_READ)
            tgt_idx = hit_reg ? hit_idx_reg : cand_idx_reg[0];
        else
            tgt_idx = bbc_pkg::SLOT_W'(slot_in_reg);
        rc_cur     = ref_count_reg[tgt_idx];
        rc_new     = rc_cur;
        wr_rc      = 1'b0;
        wr_tag     = 1'b0;
        wr_stamp   = 1'b0;
        res_slot   = slot_in_reg;
        res_hit    = 1'b0;
        res_fill   = 1'b0;
        res_status = bbc_pkg::ST_OK;
        case (op_reg)
            bbc_pkg::OP_READ:
            begin
                res_slot = 5'(tgt_idx);
                if (hit_reg)
                begin
                    res_hit  = 1'b1;
                    res_fill = !slot_valid_reg[tgt_idx];
                    wr_stamp = 1'b1;
                    if (rc_cur == bbc_pkg::RC_MAX)
                        res_status = bbc_pkg::ST_COUNT;
                    else
                    begin
                        wr_rc  = 1'b1;
                        rc_new = rc_cur + 8'd1;
                    end
                end
                else if (cand_ok_reg[0])
                begin
                    wr_tag   = 1'b1;
                    wr_stamp = 1'b1;
                    wr_rc    = 1'b1;
                    rc_new   = 8'd1;
                    res_fill = 1'b1;
                end
                else
                begin
                    res_slot   = 5'd0;
                    res_status = bbc_pkg::ST_NOFREE;
                end
            end
            bbc_pkg::OP_PIN:
            begin
                if (!slot_ok || rc_cur == bbc_pkg::RC_MAX)
                    res_status = bbc_pkg::ST_COUNT;
                else
                begin
                    wr_rc  = 1'b1;
                    rc_new = rc_cur + 8'd1;
                end
            end
            default:
            begin
                // release and unpin
                if (!slot_ok || rc_cur == 8'd0)
                    res_status = bbc_pkg::ST_COUNT;
                else
                begin
                    wr_rc  = 1'b1;
                    rc_new = rc_cur - 8'd1;
                end
            end
        endcase
    end

    // cache state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bbc_pkg::SLOTS; i++)
            begin
                tag_dev_reg[i]    <= '0;
                tag_block_reg[i]  <= '0;
                slot_valid_reg[i] <= 1'b0;
                ref_count_reg[i]  <= '0;
                last_use_reg[i]   <= '0;
            end
            use_clock_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (wr_rc)
                ref_count_reg[tgt_idx] <= rc_new;
            if (wr_tag)
            begin
                tag_dev_reg[tgt_idx]   <= dev_reg;
                tag_block_reg[tgt_idx] <= block_reg;
            end
            if (wr_stamp)
            begin
                last_use_reg[tgt_idx]   <= use_clock_reg;
                slot_valid_reg[tgt_idx] <= 1'b1;
                use_clock_reg           <= use_clock_reg + 32'd1;
            end
        end
    end

    // request capture, candidate row, shared reducer, result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op;
            dev_reg     <= dev;
            block_reg   <= block;
            slot_in_reg <= slot_in;
            hit_reg     <= any_match;
            hit_idx_reg <= match_idx;
            for (int i = 0; i < bbc_pkg::CAND_N; i++)
            begin
                if (i < bbc_pkg::SLOTS)
                begin
                    cand_stamp_reg[i] <= last_use_reg[i];
                    cand_ok_reg[i]    <= (ref_count_reg[i] == 8'd0);
                end
                else
                begin
                    cand_stamp_reg[i] <= '0;
                    cand_ok_reg[i]    <= 1'b0;
                end
                cand_idx_reg[i] <= bbc_pkg::SLOT_W'(i);
            end
        end
        else if (cmd.reduce)
        begin
            // left of each pair holds the lower slots: keep it on a tie
            for (int i = 0; i < bbc_pkg::CAND_N / 2; i++)
            begin
                if (cand_ok_reg[2*i+1] &&
                    (!cand_ok_reg[2*i] || cand_stamp_reg[2*i+1] < cand_stamp_reg[2*i]))
                begin
                    cand_stamp_reg[i] <= cand_stamp_reg[2*i+1];
                    cand_idx_reg[i]   <= cand_idx_reg[2*i+1];
                    cand_ok_reg[i]    <= 1'b1;
                end
                else
                begin
                    cand_stamp_reg[i] <= cand_stamp_reg[2*i];
                    cand_idx_reg[i]   <= cand_idx_reg[2*i];
                    cand_ok_reg[i]    <= cand_ok_reg[2*i];
                end
            end
        end
        if (cmd.commit)
        begin
            slot_reg    <= res_slot;
            hit_out_reg <= res_hit;
            fill_reg    <= res_fill;
            status_reg  <= res_status;
        end
    end

    assign slot      = slot_reg;
    assign hit       = hit_out_reg;
    assign need_fill = fill_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // a committed read hit always reports a real match
    a_hit_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && op_reg == bbc_pkg::OP_READ && hit_reg |->
            tag_dev_reg[hit_idx_reg] == dev_reg && tag_block_reg[hit_idx_reg] == block_reg)
        else $error("read hit commits on a slot whose tag does not match");

    // a miss never evicts a referenced slot
    a_evict_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && op_reg == bbc_pkg::OP_READ && !hit_reg && cand_ok_reg[0] |->
            ref_count_reg[cand_idx_reg[0]] == 8'd0)
        else $error("miss selected a slot that still holds references");

    // use clock advances by at most one per commit
    a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(use_clock_reg))
        else $error("use clock moved without a commit");
`endif

endmodule

`default_nettype wire

### hdl/bbc_ctrl.sv
// Controller of the LRU buffer cache: input handshake, reduction
// sequencing, commit and output valid. Depends on bbc_pkg.
`default_nettype none

module bbc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bbc_pkg::dp_cmd_t       cmd,
    input  wire bbc_pkg::dp_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic [bbc_pkg::LVL_W-1:0] lvl_reg, lvl_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_miss ? S_SEARCH : S_FINISH;
                end
            end
            S_SEARCH:
            begin
                cmd.reduce = 1'b1;
                if (lvl_reg == bbc_pkg::LVL_W'(bbc_pkg::LVLS - 1))
                begin
                    lvl_next   = '0;
                    state_next = S_FINISH;
                end
                else
                    lvl_next = lvl_reg + 1'b1;
            end
            S_FINISH:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                lvl_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("commit would overwrite an untaken result");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat accepted while an item is in flight");

    a_lvl_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_SEARCH |-> lvl_reg == '0)
        else $error("reduction level counter left nonzero");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not raise output valid");
`endif

endmodule

`default_nettype wire

### hdl/block_buffer_cache_lru.sv
// Top level of the LRU buffer cache: joins controller and datapath.
// Depends on bbc_pkg, bbc_ctrl and bbc_dp.
//
//   channel  handshake            payload
//   input    in_valid / in_ready  op, dev, block, slot_in
//   output   out_valid/ out_ready slot, hit, need_fill, status
//
// Read hits, release, pin and unpin: tag match in the accept cycle, count and
// timestamp update at commit, once the output register is free. Read misses first
// step through each level of the shared 16-comparator oldest-slot reducer. One
// item in flight; the result register lets a new item enter while the previous
// result still waits, and a finished item holds until it is taken. Reset clears
// all tags, counts, timestamps and valid bits.
`default_nettype none

module block_buffer_cache_lru (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  dev,
    input  wire logic [31:0] block,
    input  wire logic [4:0]  slot_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       slot,
    output logic             hit,
    output logic             need_fill,
    output logic [1:0]       status
);

    bbc_pkg::dp_cmd_t  cmd;
    bbc_pkg::dp_stat_t stat;

    bbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    bbc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .op        (op),
        .dev       (dev),
        .block     (block),
        .slot_in   (slot_in),
        .slot      (slot),
        .hit       (hit),
        .need_fill (need_fill),
        .status    (status)
    );

endmodule

`default_nettype wire
